[src/view_projection_matrix_composer_core_defines.svh]
// ----------------------------------------------------------------------------
// View-projection composer assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef VIEW_PROJECTION_MATRIX_COMPOSER_CORE_DEFINES_SVH
`define VIEW_PROJECTION_MATRIX_COMPOSER_CORE_DEFINES_SVH

// same-cycle implication
`define VPMC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VPMC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/vpmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpmc_pkg
// Types, constants and fixed-point helpers of the view-projection composer.
// ----------------------------------------------------------------------------
package vpmc_pkg;

  localparam int DIR_FRAC_BITS = 14;
  localparam int POS_FRAC_BITS = 16;
  localparam int WW            = 68;
  localparam int ONE_D         = 1 << DIR_FRAC_BITS;
  localparam int ONE_P         = 1 << POS_FRAC_BITS;

  localparam logic [2:0] REG_SCALE_X  = 3'd0;
  localparam logic [2:0] REG_SCALE_Y  = 3'd1;
  localparam logic [2:0] REG_DEPTH_Z  = 3'd2;
  localparam logic [2:0] REG_DEPTH_W  = 3'd3;
  localparam logic [2:0] REG_PLANE    = 3'd4;

  localparam logic [3:0] LAST_IDX = 4'd15;

  typedef logic signed [31:0]   word_t;
  typedef logic signed [WW-1:0] wide_t;
  typedef word_t [15:0]         mat_t;

  localparam word_t MAX32 = 32'sh7FFF_FFFF;
  localparam word_t MIN32 = 32'sh8000_0000;

  typedef struct packed {
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
    logic signed [15:0] pitch_cos;
    logic signed [15:0] pitch_sin;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
  } cam_word_t;

  typedef struct packed {
    logic        [3:0]  element_index;
    logic signed [31:0] element_value;
    logic               last_element;
  } elem_word_t;

  typedef struct packed {
    word_t scale_x;
    word_t scale_y;
    word_t depth_z;
    word_t depth_w;
    word_t plane_distance;
  } proj_t;

  localparam proj_t PROJ_RESET = '{scale_x: 32'sd98304, scale_y: 32'sd98304,
                                   depth_z: 32'sd0, depth_w: 32'sd0,
                                   plane_distance: -32'sd65536};

  // round half up, then arithmetic shift
  function automatic wide_t rnd(input wide_t v, input int unsigned sh);
    wide_t h;
    h = wide_t'(1) <<< (sh - 1);
    return (v + h) >>> sh;
  endfunction

  function automatic word_t sat32(input wide_t v);
    word_t r;
    if (v > wide_t'(MAX32)) begin
      r = MAX32;
    end else if (v < wide_t'(MIN32)) begin
      r = MIN32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic word_t mul_d(input word_t a, input word_t b);
    logic signed [63:0] p;
    p = a * b;
    return sat32(rnd(wide_t'(p), DIR_FRAC_BITS));
  endfunction

  function automatic word_t neg_sat(input word_t p);
    return (p == MIN32) ? MAX32 : -p;
  endfunction

endpackage
`default_nettype wire

[src/vpmc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpmc_front
// Seven-stage pipeline: builds pitch and yaw terms and the view matrix.
// ----------------------------------------------------------------------------
module vpmc_front import vpmc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cam_valid,
  output logic      cam_ready,
  input  cam_word_t cam_word,
  output logic      mat_valid,
  input  logic      mat_ready,
  output mat_t      mat
);

  logic fen;
  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v;

  logic signed [15:0] hx, hy, vc, vs;
  logic signed [17:0] ax, aic;

  logic signed [19:0] a_qx, a_qz, a_icx, a_xs, a_zs;
  logic signed [15:0] a_c, a_hx, a_hy;
  word_t              a_n [3];

  logic signed [19:0] b_qx, b_qz, b_qxc, b_qzc, b_icxz, b_xs, b_zs;
  logic signed [15:0] b_c, b_hx, b_hy;
  word_t              b_n [3];

  logic signed [19:0] r0, r10;
  logic signed [19:0] cp [9];
  logic signed [19:0] c_p [9];
  word_t              c_t1 [9];
  logic signed [15:0] c_hx, c_hy;
  word_t              c_n [3];

  logic signed [51:0] d_t [9];
  logic signed [47:0] d_y0 [3], d_x2 [3], d_x0 [3], d_y2 [3];
  word_t              d_m1 [3];
  logic signed [15:0] d_hx, d_hy;

  word_t              e_t [3];
  word_t              e_m0 [3], e_m1 [3], e_m2 [3];
  logic signed [15:0] e_hx, e_hy;

  logic signed [47:0] f_y0, f_x2, f_x0, f_y2;
  word_t              f_t1;
  word_t              f_m0 [3], f_m1 [3], f_m2 [3];

  mat_t g_mat, g_next;

  assign fen       = !g_v || mat_ready;
  assign cam_ready = fen;
  assign mat_valid = g_v;
  assign mat       = g_mat;

  assign hx = cam_word.heading_x;
  assign hy = cam_word.heading_y;
  assign vc = cam_word.pitch_cos;
  assign vs = cam_word.pitch_sin;

  // pitch axis is (-hy, 0, hx)
  assign ax  = -18'(hy);
  assign aic = 18'(ONE_D) - 18'(vc);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else if (fen) begin
      a_v <= cam_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
    end
  end

  always_comb begin
    r0  = b_qx + 20'(b_c) - b_qxc;
    r10 = b_qz + 20'(b_c) - b_qzc;
    cp[0] = r0;
    cp[1] = b_zs;
    cp[2] = b_icxz;
    cp[3] = -b_zs;
    cp[4] = 20'(b_c);
    cp[5] = b_xs;
    cp[6] = b_icxz;
    cp[7] = -b_xs;
    cp[8] = r10;
  end

  always_comb begin
    g_next = '0;
    for (int c = 0; c < 3; c++) begin
      g_next[c*4]   = f_m0[c];
      g_next[c*4+1] = f_m1[c];
      g_next[c*4+2] = f_m2[c];
    end
    g_next[12] = sat32(rnd(wide_t'(49'(f_y0) - 49'(f_x2)), DIR_FRAC_BITS));
    g_next[13] = f_t1;
    g_next[14] = sat32(rnd(wide_t'(49'(f_x0) + 49'(f_y2)), DIR_FRAC_BITS));
    g_next[15] = word_t'(ONE_P);
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      a_qx  <= 20'(mul_d(32'(ax), 32'(ax)));
      a_qz  <= 20'(mul_d(32'(hx), 32'(hx)));
      a_icx <= 20'(mul_d(32'(aic), 32'(ax)));
      a_xs  <= 20'(mul_d(32'(ax), 32'(vs)));
      a_zs  <= 20'(mul_d(32'(hx), 32'(vs)));
      a_c   <= vc;
      a_hx  <= hx;
      a_hy  <= hy;
      a_n[0] <= neg_sat(cam_word.position_x);
      a_n[1] <= neg_sat(cam_word.position_y);
      a_n[2] <= neg_sat(cam_word.position_z);

      b_qxc  <= 20'(mul_d(32'(a_qx), 32'(a_c)));
      b_qzc  <= 20'(mul_d(32'(a_qz), 32'(a_c)));
      b_icxz <= 20'(mul_d(32'(a_icx), 32'(a_hx)));
      b_qx   <= a_qx;
      b_qz   <= a_qz;
      b_xs   <= a_xs;
      b_zs   <= a_zs;
      b_c    <= a_c;
      b_hx   <= a_hx;
      b_hy   <= a_hy;
      b_n    <= a_n;

      for (int i = 0; i < 9; i++) begin
        c_p[i]  <= cp[i];
        c_t1[i] <= sat32(rnd(wide_t'(cp[i]) <<< POS_FRAC_BITS, DIR_FRAC_BITS));
      end
      c_hx <= b_hx;
      c_hy <= b_hy;
      c_n  <= b_n;

      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          d_t[r*3+k] <= 52'(c_p[k*3+r]) * 52'(c_n[k]);
        end
      end
      for (int c = 0; c < 3; c++) begin
        d_y0[c] <= 48'(c_hy) * 48'(c_t1[c*3]);
        d_x2[c] <= 48'(c_hx) * 48'(c_t1[c*3+2]);
        d_x0[c] <= 48'(c_hx) * 48'(c_t1[c*3]);
        d_y2[c] <= 48'(c_hy) * 48'(c_t1[c*3+2]);
        d_m1[c] <= c_t1[c*3+1];
      end
      d_hx <= c_hx;
      d_hy <= c_hy;

      for (int r = 0; r < 3; r++) begin
        e_t[r] <= sat32(rnd(wide_t'(54'(d_t[r*3]) + 54'(d_t[r*3+1]) + 54'(d_t[r*3+2])),
                            DIR_FRAC_BITS));
      end
      for (int c = 0; c < 3; c++) begin
        e_m0[c] <= sat32(rnd(wide_t'(49'(d_y0[c]) - 49'(d_x2[c])), DIR_FRAC_BITS));
        e_m2[c] <= sat32(rnd(wide_t'(49'(d_x0[c]) + 49'(d_y2[c])), DIR_FRAC_BITS));
        e_m1[c] <= d_m1[c];
      end
      e_hx <= d_hx;
      e_hy <= d_hy;

      f_y0 <= 48'(e_hy) * 48'(e_t[0]);
      f_x2 <= 48'(e_hx) * 48'(e_t[2]);
      f_x0 <= 48'(e_hx) * 48'(e_t[0]);
      f_y2 <= 48'(e_hy) * 48'(e_t[2]);
      f_t1 <= e_t[1];
      f_m0 <= e_m0;
      f_m1 <= e_m1;
      f_m2 <= e_m2;

      g_mat <= g_next;
    end
  end

endmodule
`default_nettype wire

[src/vpmc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpmc_queue
// Two-entry queue of view matrices between front and back.
// ----------------------------------------------------------------------------
module vpmc_queue import vpmc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  mat_t push_mat,
  output logic pop_valid,
  input  logic pop_ready,
  output mat_t pop_mat
);

  mat_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_mat    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_mat;
    end
  end

endmodule
`default_nettype wire

[src/vpmc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpmc_back
// Sequencer: applies the projection, one element per cycle when not stalled.
// ----------------------------------------------------------------------------
module vpmc_back import vpmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  proj_t      proj,
  input  logic       q_valid,
  output logic       q_ready,
  input  mat_t       q_mat,
  output logic       elem_valid,
  input  logic       elem_ready,
  output elem_word_t elem_word
);

  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;
  localparam logic [1:0] ROW_W = 2'd3;
  localparam logic [1:0] COL_T = 2'd3;

  logic               en;
  logic [3:0]         cnt;
  logic [1:0]         col, row;
  word_t              opa, opb;
  logic               p_v;
  logic [3:0]         p_idx;
  logic signed [63:0] p_prod, p_add;
  wide_t              sum;

  assign en      = !elem_valid || elem_ready;
  assign q_ready = en && (cnt == LAST_IDX);
  assign col     = cnt[3:2];
  assign row     = cnt[1:0];
  assign sum     = wide_t'(p_prod) + wide_t'(p_add);

  always_comb begin
    opa = proj.scale_x;
    opb = $signed(q_mat[{col, ROW_X}]);
    case (row)
      ROW_X: begin
        opa = proj.scale_x;
        opb = $signed(q_mat[{col, ROW_X}]);
      end
      ROW_Y: begin
        opa = proj.scale_y;
        opb = $signed(q_mat[{col, ROW_Y}]);
      end
      ROW_Z: begin
        opa = proj.depth_z;
        opb = $signed(q_mat[{col, ROW_Z}]);
      end
      ROW_W: begin
        opa = proj.plane_distance;
        opb = $signed(q_mat[{col, ROW_Z}]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= 4'd0;
      p_v        <= 1'b0;
      elem_valid <= 1'b0;
    end else if (en) begin
      p_v        <= q_valid;
      elem_valid <= p_v;
      if (q_valid) begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_idx  <= cnt;
      p_prod <= opa * opb;
      // translation column carries 1.0 in row w
      p_add  <= (row == ROW_Z && col == COL_T) ?
                (64'($signed(proj.depth_w)) <<< POS_FRAC_BITS) : 64'sd0;
      elem_word.element_index <= p_idx;
      elem_word.element_value <= sat32(rnd(sum, POS_FRAC_BITS));
      elem_word.last_element  <= (p_idx == LAST_IDX);
    end
  end

endmodule
`default_nettype wire

[src/view_projection_matrix_composer_core.sv]
// Throughput: one element word per cycle while a matrix is queued and elem_ready
// does not stall, set by the single projection multiplier in the back sequencer,
// which pops a matrix from the queue only as it issues that matrix's last element.
// The front pipeline takes a new camera word every cycle while its queue has room.
// Reset (rst, synchronous): pipeline and queue empty, projection registers
// return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// view_projection_matrix_composer_core
// Builds proj * yaw * pitch * translate and streams its 16 elements.
// ----------------------------------------------------------------------------
module view_projection_matrix_composer_core import vpmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cam_valid,
  output logic        cam_ready,
  input  cam_word_t   cam_word,
  output logic        elem_valid,
  input  logic        elem_ready,
  output elem_word_t  elem_word,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  proj_t proj;
  logic  f_valid, f_ready, q_valid, q_ready;
  mat_t  f_mat, q_mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      proj <= PROJ_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE_X: proj.scale_x        <= cfg_data;
        REG_SCALE_Y: proj.scale_y        <= cfg_data;
        REG_DEPTH_Z: proj.depth_z        <= cfg_data;
        REG_DEPTH_W: proj.depth_w        <= cfg_data;
        REG_PLANE:   proj.plane_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  vpmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cam_valid (cam_valid),
    .cam_ready (cam_ready),
    .cam_word  (cam_word),
    .mat_valid (f_valid),
    .mat_ready (f_ready),
    .mat       (f_mat)
  );

  vpmc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_mat   (f_mat),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_mat    (q_mat)
  );

  vpmc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .proj       (proj),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_mat      (q_mat),
    .elem_valid (elem_valid),
    .elem_ready (elem_ready),
    .elem_word  (elem_word)
  );

endmodule
`default_nettype wire

[src/vpmc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpmc_checker
// Port-level checks on element ordering and word flow.
// ----------------------------------------------------------------------------
`include "view_projection_matrix_composer_core_defines.svh"

module vpmc_checker import vpmc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       cam_valid,
  input logic       cam_ready,
  input logic       elem_valid,
  input logic       elem_ready,
  input elem_word_t elem_word
);

  logic [3:0] exp_idx;
  logic [4:0] pending;
  logic       cam_acc, mat_done;

  assign cam_acc  = cam_valid && cam_ready;
  assign mat_done = elem_valid && elem_ready && elem_word.last_element;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= 4'd0;
      pending <= 5'd0;
    end else begin
      if (elem_valid && elem_ready) begin
        exp_idx <= exp_idx + 4'd1;
      end
      pending <= pending + 5'(cam_acc) - 5'(mat_done);
    end
  end

  `VPMC_ASSERT_IMP(a_last_flag, elem_valid, elem_word.last_element == (elem_word.element_index == LAST_IDX), "last flag not on final element")
  `VPMC_ASSERT_IMP(a_index_order, elem_valid, elem_word.element_index == exp_idx, "element index out of order")
  `VPMC_ASSERT_IMP(a_no_orphan, elem_valid, pending != 5'd0, "element word without camera word")
  `VPMC_ASSERT_NXT(a_hold, elem_valid && !elem_ready, elem_valid && $stable(elem_word), "element word changed while stalled")

endmodule

bind view_projection_matrix_composer_core vpmc_checker u_checker (.*);
`default_nettype wire
